// File: sv/itrt_pkg.sv
// shared constants, types and the digit glyph function for integer to radix text
// no dependencies
package itrt_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int RADIX_W        = 6;
    localparam int DIGIT_W        = 6;
    localparam int CHAR_W         = 7;

    localparam logic [RADIX_W-1:0] MIN_RADIX = 6'd2;
    localparam logic [RADIX_W-1:0] MAX_RADIX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOWER  = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS  = 7'h2d;
    localparam logic [CHAR_W-1:0] CHAR_NONE   = 7'h00;
    localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;

    typedef struct packed {
        logic load;
        logic next;
    } div_cmd_t;

    typedef struct packed {
        logic               done;
        logic               nonzero;
        logic [DIGIT_W-1:0] rem;
    } div_res_t;

    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_DIGITS)
        begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = CHAR_LOWER + CHAR_W'(d - DEC_DIGITS);
        end
        return c;
    endfunction

endpackage

// File: sv/itrt_divider.sv
// bit-serial restoring divider: one quotient bit per cycle, remainder below the radix
// depends on itrt_pkg
module itrt_divider
    import itrt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  div_cmd_t              cmd,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [RADIX_W-1:0]    divisor,
    output div_res_t              res
);

    localparam int CNT_W = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] q_reg, q_next;
    logic [DIGIT_W-1:0]    r_reg, r_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  run_reg;
    logic                  done_reg;
    logic                  nz_reg, nz_next;
    logic [DIGIT_W:0]      trial;
    logic                  qbit;
    logic                  last_step;

    always_comb
    begin
        trial     = {r_reg, q_reg[VALUE_BITS-1]};
        qbit      = (trial >= {1'b0, divisor});
        r_next    = qbit ? DIGIT_W'(trial - {1'b0, divisor}) : trial[DIGIT_W-1:0];
        q_next    = {q_reg[VALUE_BITS-2:0], qbit};
        nz_next   = nz_reg | qbit;
        last_step = run_reg && (cnt_reg == CNT_W'(VALUE_BITS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            nz_reg   <= 1'b0;
            q_reg    <= '0;
            r_reg    <= '0;
        end
        else
        begin
            done_reg <= last_step;
            if (cmd.load || cmd.next)
            begin
                if (cmd.load)
                begin
                    q_reg <= dividend;
                end
                r_reg   <= '0;
                cnt_reg <= '0;
                nz_reg  <= 1'b0;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                q_reg   <= q_next;
                r_reg   <= r_next;
                nz_reg  <= nz_next;
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    assign res.done    = done_reg;
    assign res.nonzero = nz_reg;
    assign res.rem     = r_reg;

endmodule

// File: sv/integer_to_radix_text_top.sv
// integer to radix text: converts one value into ASCII digits, most significant first
// depends on itrt_pkg and itrt_divider
// A transaction is taken when start is high and busy is low; value, kind and radix are
// sampled then. Each digit comes from a bit-serial divider, and busy stays high until the
// last character is sent. A '-' leads the digits of a negative signed value (radix 10
// only). Characters then come out one per cycle on consecutive cycles, each marked by
// strobe for exactly one cycle; the receiver must take them as they come. A radix
// outside 2..36 gives one strobe with empty_res and last_char set the cycle after start,
// and busy never rises.
module integer_to_radix_text_top
    import itrt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  kind,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [RADIX_W-1:0]    radix,
    output logic                  strobe,
    output logic [CHAR_W-1:0]     character,
    output logic                  last_char,
    output logic                  empty_res
);

    localparam int IDX_W = $clog2(VALUE_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t                state_reg;
    logic [RADIX_W-1:0]    radix_reg;
    logic                  minus_reg;
    logic [IDX_W-1:0]      cnt_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  strobe_reg;
    logic [CHAR_W-1:0]     character_reg;
    logic                  last_reg;
    logic                  empty_reg;

    logic [DIGIT_W-1:0]    store [VALUE_BITS];
    logic [DIGIT_W-1:0]    rd_reg;
    logic [IDX_W-1:0]      rd_addr;

    logic                  accept;
    logic                  radix_ok;
    logic                  negative;
    logic [VALUE_BITS-1:0] magnitude;
    div_cmd_t              div_cmd;
    div_res_t              div_res;

    always_comb
    begin
        accept    = start && (state_reg == ST_IDLE);
        radix_ok  = (radix >= MIN_RADIX) && (radix <= MAX_RADIX);
        negative  = kind && value[VALUE_BITS-1];
        magnitude = negative ? (~value + VALUE_BITS'(1)) : value;
        div_cmd.load = accept && radix_ok;
        div_cmd.next = (state_reg == ST_DIV) && div_res.done && div_res.nonzero;
        rd_addr = (state_reg == ST_EMIT) ? (idx_reg - IDX_W'(1)) : idx_reg;
    end

    itrt_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .dividend (magnitude),
        .divisor  (radix_reg),
        .res      (div_res)
    );

    // digit store, least significant digit first
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DIV) && div_res.done)
        begin
            store[cnt_reg] <= div_res.rem;
        end
        rd_reg <= store[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radix_reg     <= '0;
            minus_reg     <= 1'b0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            strobe_reg    <= 1'b0;
            character_reg <= CHAR_NONE;
            last_reg      <= 1'b0;
            empty_reg     <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (radix_ok)
                        begin
                            radix_reg <= radix;
                            minus_reg <= negative && (radix == RADIX_DEC);
                            cnt_reg   <= '0;
                            state_reg <= ST_DIV;
                        end
                        else
                        begin
                            strobe_reg    <= 1'b1;
                            character_reg <= CHAR_NONE;
                            last_reg      <= 1'b1;
                            empty_reg     <= 1'b1;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_res.done)
                    begin
                        cnt_reg <= cnt_reg + IDX_W'(1);
                        if (!div_res.nonzero)
                        begin
                            idx_reg   <= cnt_reg;
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD:
                begin
                    state_reg <= minus_reg ? ST_SIGN : ST_EMIT;
                end
                ST_SIGN:
                begin
                    strobe_reg    <= 1'b1;
                    character_reg <= CHAR_MINUS;
                    last_reg      <= 1'b0;
                    empty_reg     <= 1'b0;
                    state_reg     <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    strobe_reg    <= 1'b1;
                    character_reg <= glyph(rd_reg);
                    last_reg      <= (idx_reg == '0);
                    empty_reg     <= 1'b0;
                    idx_reg       <= idx_reg - IDX_W'(1);
                    if (idx_reg == '0)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign strobe    = strobe_reg;
    assign character = character_reg;
    assign last_char = last_reg;
    assign empty_res = empty_reg;

endmodule

// File: sv/itrt_checker.sv
// port-level checks for integer_to_radix_text_top, attached by bind
// depends on itrt_pkg
module itrt_checker
    import itrt_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic [RADIX_W-1:0]    radix,
    input logic                  strobe,
    input logic [CHAR_W-1:0]     character,
    input logic                  last_char,
    input logic                  empty_res
);

    // invalid radix answers at once with one empty transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && ((radix < MIN_RADIX) || (radix > MAX_RADIX)))
        |=> (strobe && empty_res && last_char && !busy))
        else $error("invalid radix not answered by an empty transaction");

    // valid radix starts a conversion
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (radix >= MIN_RADIX) && (radix <= MAX_RADIX)) |=> busy)
        else $error("valid radix did not raise busy");

    // empty result carries no character
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && empty_res) |-> (last_char && (character == CHAR_NONE)))
        else $error("empty result with a character");

    // characters of one number come out back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last_char) |=> strobe)
        else $error("gap inside a number's text");

endmodule

bind integer_to_radix_text_top itrt_checker u_itrt_checker (.*);

// File: tb/integer_to_radix_text_top_test.sv
// self-checking testbench for integer_to_radix_text_top: drives numbers and checks each character
// depends on itrt_pkg and the integer_to_radix_text_top rtl
module integer_to_radix_text_top_test
    import itrt_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BITS      = 32;
    localparam int RANDOM_ITEMS  = 89;
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 100;
    localparam string GLYPH_SET  = "0123456789abcdefghijklmnopqrstuvwxyz";

    typedef struct {
        logic                kind;
        logic [NUM_BITS-1:0] value;
        logic [RADIX_W-1:0]  radix;
        logic                drain;
    } number_item_t;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              empty;
    } text_char_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                kind = 1'b0;
    logic [NUM_BITS-1:0] value = '0;
    logic [RADIX_W-1:0]  radix = '0;
    logic                busy;
    logic                strobe;
    logic [CHAR_W-1:0]   character;
    logic                last_char;
    logic                empty_res;

    number_item_t pending_numbers_q[$];
    text_char_t   expected_text_q[$];
    number_item_t next_number;
    text_char_t   seen_char;
    logic         taken;
    int           numbers_taken = 0;
    int           numbers_total = 0;
    int           fail_count = 0;
    int           stall_cycles = 0;

    integer_to_radix_text_top #(
        .VALUE_BITS (NUM_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .value     (value),
        .radix     (radix),
        .strobe    (strobe),
        .character (character),
        .last_char (last_char),
        .empty_res (empty_res)
    );

    always #5 clk = ~clk;

    function automatic void predict_text(input logic k, input logic [NUM_BITS-1:0] v,
                                         input logic [RADIX_W-1:0] r);
        logic [NUM_BITS-1:0] mag;
        logic [NUM_BITS-1:0] base;
        logic [5:0]          digits [NUM_BITS];
        logic                neg;
        int                  n;
        text_char_t          c;
        if (r < MIN_RADIX || r > MAX_RADIX)
        begin
            c = '{CHAR_NONE, 1'b1, 1'b1};
            expected_text_q.push_back(c);
            return;
        end
        neg  = k && v[NUM_BITS-1];
        mag  = neg ? (~v + 1'b1) : v;
        base = NUM_BITS'(r);
        n    = 0;
        do
        begin
            digits[n] = 6'(mag % base);
            n++;
            mag = mag / base;
        end
        while (mag != 0);
        if (neg && r == RADIX_DEC)
        begin
            c = '{CHAR_MINUS, 1'b0, 1'b0};
            expected_text_q.push_back(c);
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            c = '{CHAR_W'(GLYPH_SET[digits[i]]), (i == 0), 1'b0};
            expected_text_q.push_back(c);
        end
    endfunction

    function automatic void push_number(input logic k, input logic [NUM_BITS-1:0] v,
                                        input logic [RADIX_W-1:0] r, input logic d);
        number_item_t item;
        item = '{k, v, r, d};
        pending_numbers_q.push_back(item);
    endfunction

    function automatic logic [NUM_BITS-1:0] random_value();
        logic [NUM_BITS-1:0] v;
        case ($urandom_range(5))
            0: v = $urandom_range(1000);
            1: v = -NUM_BITS'($urandom_range(1000));
            2: v = NUM_BITS'(1) << $urandom_range(NUM_BITS - 1);
            3: v = (NUM_BITS'(1) << $urandom_range(NUM_BITS - 1)) - 1'b1;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [RADIX_W-1:0] random_radix();
        logic [RADIX_W-1:0] r;
        case ($urandom_range(9))
            0: r = $urandom_range(1) == 0 ? RADIX_W'($urandom_range(1))
                                          : RADIX_W'($urandom_range(63, 37));
            1, 2: r = RADIX_DEC;
            default: r = RADIX_W'($urandom_range(36, 2));
        endcase
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            kind  <= 1'b0;
            value <= '0;
            radix <= '0;
        end
        else
        begin
            taken = start && !busy;
            if (taken)
            begin
                predict_text(kind, value, radix);
                numbers_taken++;
            end
            if (!start || taken)
            begin
                if (pending_numbers_q.size() != 0
                    && !(pending_numbers_q[0].drain && (expected_text_q.size() != 0 || busy))
                    && !((numbers_taken < 50 || numbers_taken >= 85)
                         && $urandom_range(99) < 8))
                begin
                    next_number = pending_numbers_q.pop_front();
                    start <= 1'b1;
                    kind  <= next_number.kind;
                    value <= next_number.value;
                    radix <= next_number.radix;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (expected_text_q.size() == 0)
            begin
                $display("%0t: unexpected character: expected none, actual %h last %b empty %b",
                         $time, character, last_char, empty_res);
                fail_count++;
            end
            else
            begin
                seen_char = expected_text_q.pop_front();
                if (character !== seen_char.ch)
                begin
                    $display("%0t: character mismatch: expected %h, actual %h",
                             $time, seen_char.ch, character);
                    fail_count++;
                end
                if (last_char !== seen_char.last)
                begin
                    $display("%0t: last_char mismatch: expected %b, actual %b",
                             $time, seen_char.last, last_char);
                    fail_count++;
                end
                if (empty_res !== seen_char.empty)
                begin
                    $display("%0t: empty_res mismatch: expected %b, actual %b",
                             $time, seen_char.empty, empty_res);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        push_number(1'b0, 32'h0000_0000, 6'd10, 1'b0);
        push_number(1'b0, 32'hffff_ffff, 6'd2,  1'b0);
        push_number(1'b0, 32'hffff_ffff, 6'd36, 1'b0);
        push_number(1'b0, 32'hffff_ffff, 6'd10, 1'b0);
        push_number(1'b0, 32'hdead_beef, 6'd16, 1'b0);
        push_number(1'b0, 32'd35,        6'd36, 1'b0);
        push_number(1'b1, 32'hffff_ffff, 6'd10, 1'b0);
        push_number(1'b1, 32'hffff_ffff, 6'd16, 1'b0);
        push_number(1'b1, 32'h8000_0000, 6'd10, 1'b0);
        push_number(1'b1, 32'h8000_0000, 6'd2,  1'b0);
        push_number(1'b1, 32'h7fff_ffff, 6'd10, 1'b0);
        push_number(1'b0, 32'h8000_0000, 6'd10, 1'b1);
        push_number(1'b1, 32'h0000_0000, 6'd2,  1'b0);
        push_number(1'b1, 32'hffff_fff0, 6'd8,  1'b0);
        push_number(1'b0, 32'h1234_5678, 6'd3,  1'b0);
        push_number(1'b1, 32'h1234_5678, 6'd0,  1'b0);
        push_number(1'b0, 32'hffff_ffff, 6'd1,  1'b0);
        push_number(1'b1, 32'h8000_0000, 6'd37, 1'b0);
        push_number(1'b0, 32'h0000_0000, 6'd63, 1'b0);
        push_number(1'b0, 32'd36,        6'd36, 1'b0);
        push_number(1'b1, 32'hffff_ff9c, 6'd35, 1'b1);
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            push_number(1'($urandom_range(1)), random_value(), random_radix(), (i % 37) == 36);
        end
        numbers_total = pending_numbers_q.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (numbers_taken < numbers_total)
        begin
            @(posedge clk);
        end
        while (expected_text_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
